### rtl/ffh_pkg.sv
// Shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package ffh_pkg;

  localparam int ADDR_W = 20;
  localparam int SIZE_W = 21;
  localparam int NEED_W = 22;

  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 40;

  localparam int SPLIT_SLACK = 32;
  localparam int ALIGN_MASK  = 7;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NOP    = 2'd3
  } ffh_action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_DBLFREE = 2'd2,
    ST_UNKNOWN = 2'd3
  } ffh_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_PASS,
    S_EVAL,
    S_DONE
  } ffh_state_e;

  typedef enum logic [1:0] {
    PH_LOOKUP,
    PH_ALLOC,
    PH_FREE
  } ffh_phase_e;

  typedef struct packed {
    ffh_action_e        action;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  size_bytes;
  } ffh_req_t;

  typedef struct packed {
    ffh_status_e        status;
    logic [ADDR_W-1:0]  result_address;
    logic [SIZE_W-1:0]  granted_bytes;
    logic [SIZE_W-1:0]  used_bytes;
    logic [SIZE_W-1:0]  free_bytes;
  } ffh_rsp_t;

  // one table entry as it travels around the ring
  typedef struct packed {
    logic               valid;
    logic               free;
    logic [ADDR_W-1:0]  start;
    logic [SIZE_W-1:0]  size;
  } ffh_entry_t;

endpackage

### rtl/ffh_cell.sv
// One ring cell holding a single block table entry
`timescale 1ns / 1ps
module ffh_cell import ffh_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter bit IS_FIRST     = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  ffh_entry_t ent_i,
  output ffh_entry_t ent_o
);

  ffh_entry_t ent_q;

  // the first cell starts as the whole heap, all others empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.valid <= IS_FIRST;
      ent_q.free  <= IS_FIRST;
      ent_q.start <= '0;
      ent_q.size  <= SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    end else if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;

endmodule

### rtl/ffh_ctrl.sv
// Sequencer that streams the entry ring past one edit stage
`timescale 1ns / 1ps
module ffh_ctrl import ffh_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  ffh_req_t   req_i,
  output logic       busy,
  output logic       done_o,
  output ffh_rsp_t   rsp_o,
  input  ffh_entry_t head_i,
  output ffh_entry_t tail_o,
  output logic       shift_o
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int PW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [SIZE_W-1:0] HDR   = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HEAP  = SIZE_W'(HEAP_BYTES);
  localparam logic [CW-1:0]     CMAX  = CW'(MAX_BLOCKS);
  localparam logic [PW-1:0]     PLAST = PW'(MAX_BLOCKS - 1);

  ffh_state_e state_q, state_d;
  ffh_phase_e phase_q, phase_d;
  logic resize_q, resize_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [SIZE_W-1:0] req_q, req_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pcnt_q, pcnt_d;
  logic [SIZE_W-1:0] used_q, used_d;
  ffh_entry_t h_q, h_d;
  logic hit_q, hit_d, hitfree_q, hitfree_d;
  logic [SIZE_W-1:0] hitsize_q, hitsize_d;
  ffh_status_e status_q, status_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;
  logic [SIZE_W-1:0] granted_q, granted_d;

  logic accept, aligned, pass_last, eval_done, enter_done;
  ffh_entry_t xm, ins;
  logic addr_match, fit, split;

  assign accept    = start && !busy;
  assign aligned   = !h_q.valid && head_i.valid && (head_i.start == '0);
  assign pass_last = (pcnt_q == PLAST);

  assign addr_match = head_i.valid && (({1'b0, head_i.start} + HDR) == {1'b0, addr_q});
  assign fit   = head_i.valid && head_i.free && ({1'b0, head_i.size} >= need_q);
  assign split = ({2'b0, head_i.size} >= ({1'b0, need_q} + 23'(HEADER_BYTES) + 23'(SPLIT_SLACK)))
                 && (cnt_q < CMAX);

  // ring edit stage: one entry in from the head, one out to the tail
  always_comb begin
    xm        = head_i;
    ins       = head_i;
    tail_o    = head_i;
    h_d       = h_q;
    hit_d     = hit_q;
    hitfree_d = hitfree_q;
    hitsize_d = hitsize_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    raddr_d   = raddr_q;
    granted_d = granted_q;
    shift_o   = 1'b0;
    pcnt_d    = pcnt_q;
    if (state_q == S_ALIGN) begin
      shift_o = !aligned;
      hit_d   = 1'b0;
      pcnt_d  = '0;
      if (h_q.valid) begin
        tail_o = h_q;
        h_d    = head_i;
      end
    end else if (state_q == S_PASS) begin
      shift_o = 1'b1;
      pcnt_d  = pcnt_q + PW'(1);
      case (phase_q)
        PH_LOOKUP: begin
          if (addr_match && !hit_q) begin
            hit_d     = 1'b1;
            hitfree_d = head_i.free;
            hitsize_d = head_i.size;
          end
        end
        PH_ALLOC: begin
          if (fit && !hit_q) begin
            hit_d   = 1'b1;
            xm.free = 1'b0;
            if (split) begin
              xm.size   = need_q[SIZE_W-1:0];
              ins.valid = 1'b1;
              ins.free  = 1'b1;
              ins.start = ADDR_W'({1'b0, head_i.start} + HDR + need_q[SIZE_W-1:0]);
              ins.size  = head_i.size - need_q[SIZE_W-1:0] - HDR;
              cnt_d     = cnt_q + CW'(1);
            end
            raddr_d   = ADDR_W'({1'b0, head_i.start} + HDR);
            granted_d = xm.size;
            used_d    = used_q + xm.size + HDR;
          end
          // a held entry pushes the stream back by one until a gap swallows it
          if (h_q.valid) begin
            tail_o = h_q;
            h_d    = xm;
          end else if (fit && !hit_q && split) begin
            tail_o = xm;
            h_d    = ins;
          end else begin
            tail_o = xm;
          end
        end
        PH_FREE: begin
          if (addr_match && !hit_q) begin
            hit_d     = 1'b1;
            hitfree_d = head_i.free;
            if (!head_i.free) begin
              xm.free = 1'b1;
              used_d  = used_q - head_i.size - HDR;
            end
          end
          // hold the last entry so a free neighbor can fold into it
          if (!xm.valid) begin
            tail_o = xm;
          end else if (h_q.valid && h_q.free && xm.free) begin
            h_d.size     = h_q.size + HDR + xm.size;
            tail_o       = xm;
            tail_o.valid = 1'b0;
            cnt_d        = cnt_q - CW'(1);
          end else begin
            tail_o = h_q;
            h_d    = xm;
          end
        end
        default: begin
          tail_o = head_i;
        end
      endcase
    end else if (state_q == S_EVAL) begin
      // resize that fits returns the same block with its own size
      if (phase_q == PH_LOOKUP && hit_q && !hitfree_q && (hitsize_q >= req_q)) begin
        raddr_d   = addr_q;
        granted_d = hitsize_q;
      end
    end
  end

  // request decode and end-of-pass decisions
  always_comb begin
    phase_d    = phase_q;
    resize_d   = resize_q;
    addr_d     = addr_q;
    req_d      = req_q;
    need_d     = need_q;
    status_d   = status_q;
    eval_done  = 1'b0;
    enter_done = 1'b0;
    if (accept) begin
      addr_d   = req_i.address;
      req_d    = req_i.size_bytes;
      need_d   = ({1'b0, req_i.size_bytes} + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK);
      status_d = ST_OK;
      resize_d = 1'b0;
      if (req_i.action == ACT_ALLOC ||
          (req_i.action == ACT_RESIZE && req_i.address == '0)) begin
        phase_d    = PH_ALLOC;
        enter_done = (req_i.size_bytes == '0);
      end else if (req_i.action == ACT_FREE ||
                   (req_i.action == ACT_RESIZE && req_i.size_bytes == '0)) begin
        phase_d    = PH_FREE;
        enter_done = (req_i.address == '0);
      end else if (req_i.action == ACT_RESIZE) begin
        phase_d = PH_LOOKUP;
      end else begin
        enter_done = 1'b1;
      end
    end else if (state_q == S_EVAL) begin
      case (phase_q)
        PH_LOOKUP: begin
          if (!hit_q) begin
            status_d  = ST_UNKNOWN;
            eval_done = 1'b1;
          end else if (hitfree_q) begin
            status_d  = ST_DBLFREE;
            eval_done = 1'b1;
          end else if (hitsize_q >= req_q) begin
            eval_done = 1'b1;
          end else begin
            phase_d  = PH_ALLOC;
            resize_d = 1'b1;
          end
        end
        PH_ALLOC: begin
          if (!hit_q) begin
            status_d  = ST_NOFIT;
            eval_done = 1'b1;
          end else if (resize_q) begin
            phase_d = PH_FREE;
          end else begin
            eval_done = 1'b1;
          end
        end
        PH_FREE: begin
          eval_done = 1'b1;
          if (!resize_q) begin
            if (!hit_q) status_d = ST_UNKNOWN;
            else if (hitfree_q) status_d = ST_DBLFREE;
          end
        end
        default: eval_done = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = enter_done ? S_DONE : S_ALIGN;
      S_ALIGN: if (aligned) state_d = S_PASS;
      S_PASS:  if (pass_last) state_d = S_EVAL;
      S_EVAL:  state_d = eval_done ? S_DONE : S_ALIGN;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy                 = (state_q != S_IDLE);
    done_o               = (state_q == S_DONE);
    rsp_o.status         = status_q;
    rsp_o.result_address = raddr_q;
    rsp_o.granted_bytes  = granted_q;
    rsp_o.used_bytes     = used_q;
    rsp_o.free_bytes     = HEAP - used_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_ALLOC;
      resize_q <= 1'b0;
      cnt_q    <= CW'(1);
      pcnt_q   <= '0;
      used_q   <= '0;
      h_q      <= '0;
      hit_q    <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      resize_q <= resize_d;
      cnt_q    <= cnt_d;
      pcnt_q   <= pcnt_d;
      used_q   <= used_d;
      h_q      <= h_d;
      hit_q    <= hit_d;
      status_q <= status_d;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    req_q     <= req_d;
    need_q    <= need_d;
    hitfree_q <= hitfree_d;
    hitsize_q <= hitsize_d;
    if (accept) begin
      raddr_q   <= '0;
      granted_q <= '0;
    end else begin
      raddr_q   <= raddr_d;
      granted_q <= granted_d;
    end
  end

endmodule

### rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: entry ring and sequencer
//
// Usage: drive req_i and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. busy stays high until the
// result, which sits on rsp_o for exactly one cycle with done_o high and
// cannot be held off. One result per request.
// The block table is a ring of MAX_BLOCKS cells that shifts one entry per
// cycle while it aligns or passes, past a single edit stage (first-fit
// test, split, free mark, merge). Each table pass first aligns the ring so
// the entry at offset 0 is at the head, then streams MAX_BLOCKS entries.
// Allocate and free take one pass, resize up to three (lookup, allocate,
// free). Allocate of zero bytes, free of address 0 and no-op skip the
// table passes. Reset leaves one free block covering the heap and zero
// bytes in use.
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffh_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  ffh_req_t req_i,
  output logic     busy,
  output logic     done_o,
  output ffh_rsp_t rsp_o
);

  ffh_entry_t ring [MAX_BLOCKS];
  ffh_entry_t tail;
  logic       shift;

  // sequencer with the edit stage
  ffh_ctrl #(
    .HEAP_BYTES  (HEAP_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .head_i (ring[0]),
    .tail_o (tail),
    .shift_o(shift)
  );

  // chain of entry cells, each takes its upper neighbor
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffh_entry_t nxt;
    if (g == MAX_BLOCKS - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    ffh_cell #(
      .HEAP_BYTES  (HEAP_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .IS_FIRST    (g == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .ent_i  (nxt),
      .ent_o  (ring[g])
    );
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the first-fit heap allocator
`timescale 1ns / 1ps
module tb;
  import ffh_pkg::*;

  localparam int HEAP     = HEAP_BYTES_DEF;
  localparam int BLOCKS   = MAX_BLOCKS_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int N_RANDOM = 2000;
  localparam int DRAIN    = 1200;
  localparam int WATCHDOG = 30000;

  typedef struct packed {
    ffh_req_t req;
    logic     typed;
    ffh_rsp_t rsp;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  ffh_req_t req_i = '0;
  logic     busy;
  logic     done_o;
  ffh_rsp_t rsp_o;

  first_fit_heap_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the block table
  int unsigned blk_start [BLOCKS];
  int unsigned blk_size  [BLOCKS];
  bit          blk_free  [BLOCKS];
  int unsigned blk_count;
  int unsigned heap_used;

  ffh_rsp_t  expected_rsp_q[$];
  stim_row_t typed_q[$];
  int        n_accepted = 0;
  int        n_errors = 0;
  int        idle_cycles = 0;
  int        n_status[4] = '{0, 0, 0, 0};
  int        max_blocks_seen = 1;

  function automatic int find_block(int unsigned addr);
    for (int i = 0; i < blk_count; i++)
      if (blk_start[i] + HDR == addr) return i;
    return -1;
  endfunction

  function automatic void remove_block(int unsigned k);
    for (int i = k; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_size[i]  = blk_size[i+1];
      blk_free[i]  = blk_free[i+1];
    end
    blk_count--;
  endfunction

  // first fit, with split when the leftover holds a header plus slack
  function automatic ffh_status_e heap_alloc(int unsigned req, output int idx);
    int unsigned need;
    need = (req + ALIGN_MASK) & ~ALIGN_MASK;
    idx = -1;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= need) begin
        if (blk_size[i] >= need + HDR + SPLIT_SLACK && blk_count < BLOCKS) begin
          for (int j = blk_count; j > i + 1; j--) begin
            blk_start[j] = blk_start[j-1];
            blk_size[j]  = blk_size[j-1];
            blk_free[j]  = blk_free[j-1];
          end
          blk_start[i+1] = blk_start[i] + HDR + need;
          blk_size[i+1]  = blk_size[i] - need - HDR;
          blk_free[i+1]  = 1'b1;
          blk_count++;
          blk_size[i] = need;
        end
        blk_free[i] = 1'b0;
        heap_used += blk_size[i] + HDR;
        idx = i;
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  // free with coalescing of neighbors
  function automatic ffh_status_e heap_free(int unsigned addr);
    int k;
    int i;
    if (addr == 0) return ST_OK;
    k = find_block(addr);
    if (k < 0) return ST_UNKNOWN;
    if (blk_free[k]) return ST_DBLFREE;
    blk_free[k] = 1'b1;
    heap_used -= blk_size[k] + HDR;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] += HDR + blk_size[i+1];
        remove_block(i + 1);
      end else begin
        i++;
      end
    end
    return ST_OK;
  endfunction

  function automatic ffh_rsp_t heap_step(ffh_req_t r);
    ffh_rsp_t    p;
    int          k;
    int          old;
    int unsigned req;
    p = '0;
    req = 32'(r.size_bytes);
    p.status = ST_OK;
    if (r.action == ACT_ALLOC || (r.action == ACT_RESIZE && r.address == 0)) begin
      if (req != 0) begin
        p.status = heap_alloc(req, k);
        if (p.status == ST_OK) begin
          p.result_address = ADDR_W'(blk_start[k] + HDR);
          p.granted_bytes  = SIZE_W'(blk_size[k]);
        end
      end
    end else if (r.action == ACT_FREE) begin
      p.status = heap_free(32'(r.address));
    end else if (r.action == ACT_RESIZE) begin
      if (req == 0) begin
        p.status = heap_free(32'(r.address));
      end else begin
        old = find_block(32'(r.address));
        if (old < 0) p.status = ST_UNKNOWN;
        else if (blk_free[old]) p.status = ST_DBLFREE;
        else if (blk_size[old] >= req) begin
          p.result_address = r.address;
          p.granted_bytes  = SIZE_W'(blk_size[old]);
        end else begin
          p.status = heap_alloc(req, k);
          if (p.status == ST_OK) begin
            p.result_address = ADDR_W'(blk_start[k] + HDR);
            p.granted_bytes  = SIZE_W'(blk_size[k]);
            void'(heap_free(32'(r.address)));
          end
        end
      end
    end
    p.used_bytes = SIZE_W'(heap_used);
    p.free_bytes = SIZE_W'(HEAP - heap_used);
    return p;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // accept transactions, predict, and check results
  always @(posedge clk_i) begin
    stim_row_t row;
    ffh_rsp_t  exp_r;
    ffh_rsp_t  pred;
    if (rst_ni) begin
      idle_cycles++;
      if (done_o) begin
        idle_cycles = 0;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, rsp_o);
          n_errors++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("status", exp_r.status, rsp_o.status);
          check_field("result_address", exp_r.result_address, rsp_o.result_address);
          check_field("granted_bytes", exp_r.granted_bytes, rsp_o.granted_bytes);
          check_field("used_bytes", exp_r.used_bytes, rsp_o.used_bytes);
          check_field("free_bytes", exp_r.free_bytes, rsp_o.free_bytes);
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        row = typed_q.pop_front();
        pred = heap_step(req_i);
        exp_r = row.typed ? row.rsp : pred;
        expected_rsp_q.push_back(exp_r);
        n_status[pred.status]++;
        if (blk_count > max_blocks_seen) max_blocks_seen = blk_count;
        n_accepted++;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // one transaction, with an optional gap first
  task automatic send(stim_row_t row, int gap_pct);
    int target;
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    typed_q.push_back(row);
    target = n_accepted + 1;
    start = 1'b1;
    req_i = row.req;
    while (n_accepted < target) @(negedge clk_i);
  endtask

  function automatic stim_row_t mk(ffh_action_e a, int unsigned addr, int unsigned sz);
    stim_row_t r;
    r = '0;
    r.req.action = a;
    r.req.address = ADDR_W'(addr);
    r.req.size_bytes = SIZE_W'(sz);
    return r;
  endfunction

  function automatic stim_row_t mk_typed(ffh_action_e a, int unsigned addr, int unsigned sz,
                                        ffh_status_e st, int unsigned ra, int unsigned gr,
                                        int unsigned used);
    stim_row_t r;
    r = mk(a, addr, sz);
    r.typed = 1'b1;
    r.rsp = {st, ra[ADDR_W-1:0], gr[SIZE_W-1:0], used[SIZE_W-1:0],
             SIZE_W'(HEAP - used)};
    return r;
  endfunction

  // mostly addresses of live table entries, some zero or noise
  function automatic stim_row_t rand_row();
    int unsigned addr;
    int unsigned sz;
    int unsigned p;
    ffh_action_e a;
    p = $urandom_range(99, 0);
    a = p < 45 ? ACT_ALLOC : p < 75 ? ACT_FREE : p < 95 ? ACT_RESIZE : ACT_NOP;
    p = $urandom_range(99, 0);
    if (p < 72) addr = blk_start[$urandom_range(blk_count - 1, 0)] + HDR;
    else if (p < 82) addr = 0;
    else addr = $urandom_range(20'hFFFFF, 0);
    p = $urandom_range(99, 0);
    if (p < 55) sz = $urandom_range(512, 1);
    else if (p < 75) sz = $urandom_range(8192, 1);
    else if (p < 83) sz = 0;
    else if (p < 93) sz = $urandom_range(200000, 1);
    else sz = $urandom_range(21'h1FFFFF, 0);
    return mk(a, addr, sz);
  endfunction

  task automatic wait_drained();
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    stim_row_t dir_rows[$];
    int pct[3] = '{33, 62, 0};

    // directed rows: extremes and error codes are typed in
    dir_rows.push_back(mk_typed(ACT_NOP, 20'hFFFFF, 21'h1FFFFF, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_ALLOC, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_FREE, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_FREE, 12345, 0, ST_UNKNOWN, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_RESIZE, 20'hFFFFF, 8, ST_UNKNOWN, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_ALLOC, 0, 21'h1FFFFF, ST_NOFIT, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_ALLOC, 0, HEAP, ST_NOFIT, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_ALLOC, 0, HEAP - HDR, ST_OK, HDR, HEAP - HDR, HEAP));
    dir_rows.push_back(mk_typed(ACT_ALLOC, 0, 1, ST_NOFIT, 0, 0, HEAP));
    dir_rows.push_back(mk_typed(ACT_FREE, HDR, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_FREE, HDR, 0, ST_DBLFREE, 0, 0, 0));
    dir_rows.push_back(mk_typed(ACT_RESIZE, HDR, 16, ST_DBLFREE, 0, 0, 0));
    dir_rows.push_back(mk(ACT_ALLOC, 0, 1));
    dir_rows.push_back(mk(ACT_ALLOC, 0, 8));
    dir_rows.push_back(mk(ACT_RESIZE, 0, 16));
    dir_rows.push_back(mk(ACT_RESIZE, HDR, 4));
    dir_rows.push_back(mk(ACT_RESIZE, HDR, 100));
    dir_rows.push_back(mk(ACT_RESIZE, 96, 0));
    dir_rows.push_back(mk(ACT_FREE, 2 * HDR + 8, 0));
    dir_rows.push_back(mk(ACT_ALLOC, 0, 21'h0AAAAA));
    dir_rows.push_back(mk(ACT_ALLOC, 0, 21'h055555));
    dir_rows.push_back(mk(ACT_RESIZE, 20'h55555, 21'h100000));
    dir_rows.push_back(mk(ACT_NOP, 20'h0, 21'h0));

    // reset and predictor initial state
    for (int i = 0; i < BLOCKS; i++) begin
      blk_start[i] = 0;
      blk_size[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = HEAP - HDR;
    blk_free[0] = 1'b1;
    blk_count = 1;
    heap_used = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i], 0);
    start = 1'b0;
    wait_drained();

    // random phases: sender idles lightly, then heavily, then not at all
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < N_RANDOM / 3; n++) send(rand_row(), pct[ph]);
      start = 1'b0;
      wait_drained();
    end
    // many tiny allocations to reach a full table
    for (int n = 0; n < 80; n++) send(mk(ACT_ALLOC, 0, $urandom_range(64, 1)), 0);
    start = 1'b0;
    wait_drained();
    repeat (DRAIN) @(negedge clk_i);

    $display("%0d transactions: %0d ok, %0d no fit, %0d double free, %0d unknown",
             n_accepted, n_status[ST_OK], n_status[ST_NOFIT], n_status[ST_DBLFREE],
             n_status[ST_UNKNOWN]);
    $display("largest table seen: %0d of %0d blocks", max_blocks_seen, BLOCKS);
    if (n_errors == 0 && expected_rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
